/* src/scfp_pkg.sv */
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants of the serial command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package scfp_pkg;

  // ASCII codes recognized in a frame
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_GET   = 8'h67;  // 'g'
  localparam logic [7:0] CH_SET   = 8'h73;  // 's'
  localparam logic [7:0] CH_T     = 8'h74;  // 't'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Parameter codes
  localparam logic [1:0] PARAM_T = 2'd0;
  localparam logic [1:0] PARAM_C = 2'd1;
  localparam logic [1:0] PARAM_A = 2'd2;
  localparam logic [1:0] PARAM_B = 2'd3;

  // Request kinds
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_READY  = 3'd1,
    PH_GET    = 3'd2,
    PH_SET    = 3'd3,
    PH_PARAM  = 3'd4,
    PH_FLOAT  = 3'd5,
    PH_BUTTON = 3'd6
  } scfp_phase_t;

  typedef struct packed {
    logic       command_kind;
    logic [1:0] param_code;
    logic [1:0] digit_count;
    logic [3:0] digit_first;
    logic [3:0] digit_second;
    logic [3:0] digit_third;
  } scfp_result_t;

endpackage

`default_nettype wire

/* src/scfp_rx_if.sv */
// ----------------------------------------------------------------------------
// scfp_rx_if
// Received byte channel: valid/ready handshake with one ASCII byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/scfp_cmd_if.sv */
// ----------------------------------------------------------------------------
// scfp_cmd_if
// Parsed request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfp_cmd_if;
  logic       valid;
  logic       ready;
  logic       command_kind;
  logic [1:0] param_code;
  logic [1:0] digit_count;
  logic [3:0] digit_first;
  logic [3:0] digit_second;
  logic [3:0] digit_third;

  modport source (output valid, output command_kind, output param_code,
                  output digit_count, output digit_first, output digit_second,
                  output digit_third, input ready);
  modport sink   (input valid, input command_kind, input param_code,
                  input digit_count, input digit_first, input digit_second,
                  input digit_third, output ready);
endinterface

`default_nettype wire

/* src/serial_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Turns a stream of received ASCII bytes into get and set requests.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the request side does not stall. The byte
// that closes a frame is first held in the input register, and the parser
// step then loads the result register from it, which gives the request.
// Both registers move on whenever the result register is empty or its
// request is being taken, so a stall on the request side holds the input
// side after at most one byte.
// Frames are "#g<t|c|a>;", "#st<digits>;" (up to MAX_DIGITS digits kept,
// later ones dropped) and "#sb<0|1...>;" (last digit kept). A '#' restarts a
// frame anywhere; any other unexpected byte drops the frame silently.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_parser #(
  parameter int MAX_DIGITS = 3
) (
  input  wire logic  clk,
  input  wire logic  rst,
  scfp_rx_if.sink    rx,
  scfp_cmd_if.source cmd
);
  import scfp_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         advance;
  logic         step;
  logic         emit;
  scfp_result_t result;
  logic         cmd_valid;
  scfp_result_t cmd_q;

  assign advance  = !cmd_valid || cmd.ready;
  assign step     = byte_valid && advance;
  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) byte_q <= rx.rx_byte;
  end

  scfp_parser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (byte_q),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) cmd_q <= result;
  end

  assign cmd.valid        = cmd_valid;
  assign cmd.command_kind = cmd_q.command_kind;
  assign cmd.param_code   = cmd_q.param_code;
  assign cmd.digit_count  = cmd_q.digit_count;
  assign cmd.digit_first  = cmd_q.digit_first;
  assign cmd.digit_second = cmd_q.digit_second;
  assign cmd.digit_third  = cmd_q.digit_third;

endmodule

`default_nettype wire

/* src/scfp_parser.sv */
// ----------------------------------------------------------------------------
// scfp_parser
// Frame state machine and digit store; one byte per step, at most one request.
// ----------------------------------------------------------------------------
`default_nettype none

module scfp_parser #(
  parameter int MAX_DIGITS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  output logic                       emit,
  output scfp_pkg::scfp_result_t     result
);
  import scfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  scfp_phase_t      phase, phase_next;
  logic [1:0]       held_param;
  logic [CNT_W-1:0] digits_taken;
  logic [3:0]       digit_store [MAX_DIGITS];

  logic             is_digit;
  logic             is_bit;
  logic [3:0]       digit_val;
  logic             load_param;
  logic [1:0]       param_val;
  logic             clear_taken;
  logic             take_digit;
  logic             take_bit;
  logic             room;
  logic [CNT_W+1:0] taken_ext;
  logic [1:0]       taken_sat;
  logic [3:0]       slot_val [3];

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_bit    = (rx_byte == CH_ZERO) || (rx_byte == CH_ONE);
  assign digit_val = 4'(rx_byte - CH_ZERO);
  assign room      = digits_taken < CNT_W'(MAX_DIGITS);
  assign taken_ext = (CNT_W + 2)'(digits_taken);
  assign taken_sat = (taken_ext > (CNT_W + 2)'(3)) ? 2'd3 : taken_ext[1:0];

  // Slots beyond the count read as zero
  for (genvar i = 0; i < 3; i++) begin : g_slot
    if (i < MAX_DIGITS) begin : g_live
      assign slot_val[i] = (digits_taken > CNT_W'(i)) ? digit_store[i] : 4'd0;
    end else begin : g_dead
      assign slot_val[i] = 4'd0;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (rx_byte == CH_HASH) begin
      phase_next = PH_READY;
    end else begin
      case (phase)
        PH_READY: begin
          if (rx_byte == CH_GET) phase_next = PH_GET;
          else if (rx_byte == CH_SET) phase_next = PH_SET;
          else phase_next = PH_IDLE;
        end
        PH_GET: begin
          if (rx_byte == CH_T || rx_byte == CH_C || rx_byte == CH_A) begin
            phase_next = PH_PARAM;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_SET: begin
          if (rx_byte == CH_T) phase_next = PH_FLOAT;
          else if (rx_byte == CH_B) phase_next = PH_BUTTON;
          else phase_next = PH_IDLE;
        end
        PH_FLOAT: begin
          if (!is_digit) phase_next = PH_IDLE;
        end
        PH_BUTTON: begin
          if (!is_bit) phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Actions and request
  always_comb begin
    emit        = 1'b0;
    result      = '0;
    load_param  = 1'b0;
    param_val   = PARAM_T;
    clear_taken = 1'b0;
    take_digit  = 1'b0;
    take_bit    = 1'b0;
    if (rx_byte != CH_HASH) begin
      case (phase)
        PH_GET: begin
          load_param = 1'b1;
          if (rx_byte == CH_C) param_val = PARAM_C;
          else if (rx_byte == CH_A) param_val = PARAM_A;
          else param_val = PARAM_T;
          if (!(rx_byte == CH_T || rx_byte == CH_C || rx_byte == CH_A)) begin
            load_param = 1'b0;
          end
        end
        PH_SET: begin
          if (rx_byte == CH_T) begin
            load_param  = 1'b1;
            param_val   = PARAM_T;
            clear_taken = 1'b1;
          end else if (rx_byte == CH_B) begin
            load_param = 1'b1;
            param_val  = PARAM_B;
          end
        end
        PH_PARAM: begin
          if (rx_byte == CH_SEMI) begin
            emit                = 1'b1;
            result.command_kind = KIND_GET;
            result.param_code   = held_param;
          end
        end
        PH_FLOAT: begin
          if (is_digit) begin
            take_digit = room;
          end else if (rx_byte == CH_SEMI) begin
            emit                = 1'b1;
            result.command_kind = KIND_SET;
            result.param_code   = held_param;
            result.digit_count  = taken_sat;
            result.digit_first  = slot_val[0];
            result.digit_second = slot_val[1];
            result.digit_third  = slot_val[2];
          end
        end
        PH_BUTTON: begin
          if (is_bit) begin
            take_bit = 1'b1;
          end else if (rx_byte == CH_SEMI) begin
            emit                = 1'b1;
            result.command_kind = KIND_SET;
            result.param_code   = held_param;
            result.digit_count  = 2'd1;
            result.digit_first  = digit_store[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_param   <= PARAM_T;
      digits_taken <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) digit_store[i] <= 4'd0;
    end else if (step) begin
      phase <= phase_next;
      if (load_param) held_param <= param_val;
      if (clear_taken) begin
        digits_taken <= '0;
      end else if (take_digit) begin
        digits_taken <= digits_taken + CNT_W'(1);
      end
      if (take_digit) digit_store[digits_taken[IDX_W-1:0]] <= digit_val;
      if (take_bit) digit_store[0] <= digit_val;
    end
  end

endmodule

`default_nettype wire

/* bench/scfp_request_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scfp_request_checker
// Watches the byte and request channels of the frame parser. Each accepted
// byte is run through a local copy of the parser; the get/set requests that
// it predicts are queued and compared field by field with accepted requests.
// ----------------------------------------------------------------------------

module scfp_request_checker #(
  parameter int MAX_DIGITS = 3
) (
  input  logic clk,
  input  logic rst,
  scfp_rx_if   rx,
  scfp_cmd_if  cmd,
  output int   fail_count,
  output int   outstanding,
  output int   bytes_seen,
  output int   gets_seen,
  output int   sets_seen
);
  import scfp_pkg::*;

  scfp_phase_t  phase;
  logic [1:0]   held_code;
  int unsigned  taken;
  logic [3:0]   digits [MAX_DIGITS];
  scfp_result_t expected_requests [$];

  // digit slots past the count of kept digits read as zero
  function automatic logic [3:0] kept_digit(input int unsigned i);
    if (i < MAX_DIGITS && i < taken) return digits[i];
    return 4'd0;
  endfunction

  // Advances the local parser by one byte; returns 1 when a request results.
  function automatic bit parse_byte(input logic [7:0] b, output scfp_result_t req);
    bit is_digit;
    is_digit = (b >= CH_ZERO && b <= CH_NINE);
    req = '0;
    if (b == CH_HASH) begin
      phase = PH_READY;
      return 1'b0;
    end
    case (phase)
      PH_READY: begin
        if (b == CH_GET) phase = PH_GET;
        else if (b == CH_SET) phase = PH_SET;
        else phase = PH_IDLE;
      end
      PH_GET: begin
        phase = PH_PARAM;
        if (b == CH_T) held_code = PARAM_T;
        else if (b == CH_C) held_code = PARAM_C;
        else if (b == CH_A) held_code = PARAM_A;
        else phase = PH_IDLE;
      end
      PH_SET: begin
        if (b == CH_T) begin
          held_code = PARAM_T;
          taken = 0;
          phase = PH_FLOAT;
        end else if (b == CH_B) begin
          held_code = PARAM_B;
          phase = PH_BUTTON;
        end else begin
          phase = PH_IDLE;
        end
      end
      PH_PARAM: begin
        phase = PH_IDLE;
        if (b == CH_SEMI) begin
          req.command_kind = KIND_GET;
          req.param_code = held_code;
          return 1'b1;
        end
      end
      PH_FLOAT: begin
        if (is_digit) begin
          // digits beyond the store are dropped, frame stays open
          if (taken < MAX_DIGITS) begin
            digits[taken] = 4'(b - CH_ZERO);
            taken++;
          end
        end else begin
          phase = PH_IDLE;
          if (b == CH_SEMI) begin
            req.command_kind = KIND_SET;
            req.param_code = held_code;
            req.digit_count = (taken > 3) ? 2'd3 : 2'(taken);
            req.digit_first = kept_digit(0);
            req.digit_second = kept_digit(1);
            req.digit_third = kept_digit(2);
            return 1'b1;
          end
        end
      end
      PH_BUTTON: begin
        if (b == CH_ZERO || b == CH_ONE) begin
          digits[0] = 4'(b - CH_ZERO);
        end else begin
          phase = PH_IDLE;
          // no digit in the frame: slot 0 keeps whatever an earlier frame left
          if (b == CH_SEMI) begin
            req.command_kind = KIND_SET;
            req.param_code = held_code;
            req.digit_count = 2'd1;
            req.digit_first = digits[0];
            return 1'b1;
          end
        end
      end
      default: phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scfp_result_t req;
    if (rst) begin
      phase = PH_IDLE;
      held_code = PARAM_T;
      taken = 0;
      foreach (digits[i]) digits[i] = 4'd0;
      expected_requests.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (expected_requests.size() == 0) begin
          $display("%0t: unexpected request: kind %0d param %0d count %0d digits %0d %0d %0d",
                   $time, cmd.command_kind, cmd.param_code, cmd.digit_count,
                   cmd.digit_first, cmd.digit_second, cmd.digit_third);
          fail_count++;
        end else begin
          req = expected_requests.pop_front();
          check_field("command_kind", req.command_kind, cmd.command_kind);
          check_field("param_code", req.param_code, cmd.param_code);
          check_field("digit_count", req.digit_count, cmd.digit_count);
          check_field("digit_first", req.digit_first, cmd.digit_first);
          check_field("digit_second", req.digit_second, cmd.digit_second);
          check_field("digit_third", req.digit_third, cmd.digit_third);
          if (req.command_kind == KIND_GET) gets_seen++;
          else sets_seen++;
        end
      end
      if (rx.valid && rx.ready) begin
        bytes_seen++;
        if (parse_byte(rx.rx_byte, req)) expected_requests.push_back(req);
      end
    end
    outstanding = expected_requests.size();
  end

endmodule

/* bench/serial_command_frame_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_tb
// Feeds the frame parser directed frames, then random well-formed, broken
// and noise byte streams under random idling on both channels, a long
// request-side hold-off and a back-to-back stretch. Checking is done by
// scfp_request_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module serial_command_frame_parser_tb;
  import scfp_pkg::*;

  localparam int FRAME_BYTES     = 1750;
  localparam int IDLE_PCT        = 36;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scfp_rx_if  rx_ch ();
  scfp_cmd_if cmd_ch ();

  int fail_count;
  int outstanding;
  int bytes_seen;
  int gets_seen;
  int sets_seen;

  bit sender_idles      = 1'b1;
  bit receiver_idles    = 1'b1;
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int hold_off_left     = 0;
  int frame_bytes_sent  = 0;
  int quiet_cycles      = 0;

  always #5 clk = ~clk;

  serial_command_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .cmd(cmd_ch)
  );

  scfp_request_checker chk (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .cmd        (cmd_ch),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .bytes_seen (bytes_seen),
    .gets_seen  (gets_seen),
    .sets_seen  (sets_seen)
  );

  // request side: random stalls, plus a long hold-off when one is requested
  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        cmd_ch.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
        cmd_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (hold_off_served != hold_off_requests) begin
        cmd_ch.ready <= 1'b0;
        hold_off_served++;
        hold_off_left = HOLD_OFF_CYCLES - 1;
      end else begin
        cmd_ch.ready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("serial_command_frame_parser_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one random frame, well formed most of the time, sometimes damaged
  task automatic send_frame();
    logic [7:0] frame [$];
    int pick;
    int n;
    int pos;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
    pick = $urandom_range(99);
    frame.push_back(CH_HASH);
    if (pick < 30) begin
      frame.push_back(CH_GET);
      case ($urandom_range(2))
        0:       frame.push_back(CH_T);
        1:       frame.push_back(CH_C);
        default: frame.push_back(CH_A);
      endcase
    end else if (pick < 65) begin
      frame.push_back(CH_SET);
      frame.push_back(CH_T);
      n = ($urandom_range(5) == 0) ? $urandom_range(6) : $urandom_range(3);
      repeat (n) frame.push_back(8'(CH_ZERO + $urandom_range(9)));
    end else begin
      frame.push_back(CH_SET);
      frame.push_back(CH_B);
      n = $urandom_range(3);
      repeat (n) frame.push_back(8'(CH_ZERO + $urandom_range(1)));
    end
    frame.push_back(CH_SEMI);
    if ($urandom_range(99) < 20) begin
      pos = $urandom_range(frame.size() - 1);
      case ($urandom_range(3))
        0:       frame[pos] = CH_HASH;
        1:       frame[pos] = CH_SEMI;
        2:       frame[pos] = 8'(CH_ZERO + $urandom_range(9));
        default: frame[pos] = 8'($urandom_range(255));
      endcase
      if ($urandom_range(1) == 0) frame = frame[0:pos];
    end
    foreach (frame[i]) send_byte(frame[i]);
    frame_bytes_sent += frame.size();
  endtask

  // hold the byte side until every predicted request has come out
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bytes ignored while idle, each get, button with nothing stored,
    // excess digits, button after a numeric set, empty numeric set
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("#gt;#gc;#ga;#sb;#st9087;#sb;#st;");

    while (frame_bytes_sent < 650) send_frame();
    drain();

    hold_off_requests++;
    while (frame_bytes_sent < 850) send_frame();

    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    while (frame_bytes_sent < 1250) send_frame();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    while (frame_bytes_sent < FRAME_BYTES) send_frame();

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d bytes, %0d get and %0d set requests checked,", bytes_seen,
             gets_seen, sets_seen);
    $display("with random stalls, a %0d-cycle request hold-off and a no-idle stretch",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("serial_command_frame_parser_tb: done, clean");
    end else begin
      $display("serial_command_frame_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/scfp_pkg.sv
src/scfp_rx_if.sv
src/scfp_cmd_if.sv
src/scfp_parser.sv
src/serial_command_frame_parser.sv
bench/scfp_request_checker.sv
bench/serial_command_frame_parser_tb.sv
